@@ rtl/core/gvv_pkg.sv @@
// ----------------------------------------------------------------------------
// gvv_pkg
// Shared types and constants of the grid viewshed visibility unit.
// ----------------------------------------------------------------------------
package gvv_pkg;

    localparam int unsigned CoordW = 8;
    localparam int unsigned CountW = 9;
    localparam int unsigned HeightW = 24;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDatW = 24;

    localparam logic [CfgIdxW-1:0] CfgRowCount = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgColCount = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgNoData = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgViewRow = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgViewCol = 3'd4;

    localparam logic [1:0] StHidden = 2'd0;
    localparam logic [1:0] StVisible = 2'd1;
    localparam logic [1:0] StViewNoData = 2'd2;
    localparam logic [1:0] StOutside = 2'd3;

    typedef struct packed {
        logic kind;
        logic [CoordW-1:0] row;
        logic [CoordW-1:0] col;
        logic signed [HeightW-1:0] height;
        logic in_grid;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VP_RD,
        S_VP_WT,
        S_TG_RD,
        S_TG_WT,
        S_PASS,
        S_STEP,
        S_NORM,
        S_RD_LO,
        S_RD_HI,
        S_WT_HI,
        S_MUL,
        S_CMP,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/grid_viewshed_visibility_unit.sv @@
// ----------------------------------------------------------------------------
// grid_viewshed_visibility_unit
// Words run one at a time. Writes and off-grid queries finish in idle; a query
// whose viewpoint holds no data stops after its read. Other queries walk
// both axes, reading one cell per crossing (two if inexact).
// Reset idles control and loads config defaults; the grid stays undefined.
// ----------------------------------------------------------------------------
module grid_viewshed_visibility_unit #(
    parameter int unsigned MAX_ROWS = 256,
    parameter int unsigned MAX_COLS = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [gvv_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [gvv_pkg::CfgDatW-1:0] i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_kind,
    input  logic [gvv_pkg::CoordW-1:0] i_cell_row,
    input  logic [gvv_pkg::CoordW-1:0] i_cell_col,
    input  logic signed [gvv_pkg::HeightW-1:0] i_height,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic [gvv_pkg::CoordW-1:0] o_out_row,
    output logic [gvv_pkg::CoordW-1:0] o_out_col
);
    import gvv_pkg::*;

    logic [CountW-1:0] r_row_count, r_col_count, w_rows, w_cols;
    logic signed [HeightW-1:0] r_no_data;
    logic [CoordW-1:0] r_view_row, r_view_col;
    logic w_cmd_valid, w_cmd_ready;
    t_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CountW'(256);
            r_col_count <= CountW'(256);
            r_no_data <= -HeightW'(2559744);
            r_view_row <= '0;
            r_view_col <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgRowCount: r_row_count <= i_cfg_data[CountW-1:0];
                CfgColCount: r_col_count <= i_cfg_data[CountW-1:0];
                CfgNoData: r_no_data <= i_cfg_data;
                CfgViewRow: r_view_row <= i_cfg_data[CoordW-1:0];
                CfgViewCol: r_view_col <= i_cfg_data[CoordW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_rows = (r_row_count == '0) ? CountW'(1) : r_row_count;
        if (32'(w_rows) > MAX_ROWS) w_rows = CountW'(MAX_ROWS);
        w_cols = (r_col_count == '0) ? CountW'(1) : r_col_count;
        if (32'(w_cols) > MAX_COLS) w_cols = CountW'(MAX_COLS);
    end

    gvv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_cell_row(i_cell_row), .i_cell_col(i_cell_col),
        .i_height(i_height), .i_rows(w_rows), .i_cols(w_cols),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    gvv_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cmd_valid),
        .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd), .i_rows(w_rows), .i_cols(w_cols),
        .i_no_data(r_no_data), .i_view_row(r_view_row), .i_view_col(r_view_col),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_out_row(o_out_row), .o_out_col(o_out_col)
    );

endmodule

@@ rtl/core/gvv_front.sv @@
// ----------------------------------------------------------------------------
// gvv_front
// Accept input words, tag each one with its grid-range check and queue them.
// ----------------------------------------------------------------------------
module gvv_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_kind,
    input  logic [gvv_pkg::CoordW-1:0] i_cell_row,
    input  logic [gvv_pkg::CoordW-1:0] i_cell_col,
    input  logic signed [gvv_pkg::HeightW-1:0] i_height,
    input  logic [gvv_pkg::CountW-1:0] i_rows,
    input  logic [gvv_pkg::CountW-1:0] i_cols,
    output logic                      o_cmd_valid,
    input  logic                      i_cmd_ready,
    output gvv_pkg::t_cmd             o_cmd
);
    import gvv_pkg::*;

    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd w_in;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_cmd_valid && i_cmd_ready;

    always_comb begin
        w_in.kind = i_kind;
        w_in.row = i_cell_row;
        w_in.col = i_cell_col;
        w_in.height = i_height;
        w_in.in_grid = ({1'b0, i_cell_row} < i_rows) && ({1'b0, i_cell_col} < i_cols);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

@@ rtl/core/gvv_back.sv @@
// ----------------------------------------------------------------------------
// gvv_back
// Execute queued words: store in-grid writes in the grid memory, walk sight
// lines for in-grid queries with viewpoint data, and hold one result word.
// ----------------------------------------------------------------------------
module gvv_back #(
    parameter int unsigned MAX_ROWS = 256,
    parameter int unsigned MAX_COLS = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  gvv_pkg::t_cmd             i_cmd,
    input  logic [gvv_pkg::CountW-1:0] i_rows,
    input  logic [gvv_pkg::CountW-1:0] i_cols,
    input  logic signed [gvv_pkg::HeightW-1:0] i_no_data,
    input  logic [gvv_pkg::CoordW-1:0] i_view_row,
    input  logic [gvv_pkg::CoordW-1:0] i_view_col,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic [gvv_pkg::CoordW-1:0] o_out_row,
    output logic [gvv_pkg::CoordW-1:0] o_out_col
);
    import gvv_pkg::*;

    localparam int unsigned RowAw = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned ColAw = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned Aw = RowAw + ColAw;
    localparam int unsigned Depth = 2 ** Aw;
    localparam int unsigned Dw = 10;
    localparam int unsigned Pw = 48;

    logic signed [HeightW-1:0] r_mem [Depth];
    logic signed [HeightW-1:0] r_rd;
    logic [Aw-1:0] w_rd_addr;
    logic w_rd_oob;
    logic r_rd_oob;

    t_state r_state, n_state;
    logic r_pass, n_pass;
    logic signed [Dw-1:0] r_dmaj, r_dmin;
    logic [Dw-1:0] r_den, r_k;
    logic signed [Dw:0] r_rem;
    logic signed [Dw-1:0] r_q;
    logic signed [HeightW:0] r_vp, r_dt;
    logic signed [HeightW-1:0] r_lo;
    logic r_exact;
    logic r_strict;
    logic signed [Pw-1:0] r_num, r_lhs, r_p2;
    logic r_skip;
    logic [CoordW-1:0] r_trow, r_tcol;
    logic r_ovalid;
    logic [1:0] r_ostatus;
    logic [CoordW-1:0] r_orow, r_ocol;

    logic signed [Dw:0] w_maj, w_mnr, w_rr, w_cc;
    logic signed [Dw-1:0] w_vmaj, w_vmin;
    logic w_fire_done;
    logic [1:0] w_status;
    logic w_rd_en;
    logic signed [Dw:0] w_mnr_sel;
    logic w_hi_sel;
    logic w_rem_over, w_rem_under;
    logic w_block;

    assign o_valid = r_ovalid;
    assign o_status = r_ostatus;
    assign o_out_row = r_orow;
    assign o_out_col = r_ocol;

    assign w_vmaj = r_pass ? Dw'(i_view_col) : Dw'(i_view_row);
    assign w_vmin = r_pass ? Dw'(i_view_row) : Dw'(i_view_col);
    assign w_maj = (Dw+1)'(w_vmaj) + ((r_dmaj < 0) ? -(Dw+1)'(r_k) : (Dw+1)'(r_k));
    assign w_hi_sel = (r_state == S_RD_HI);
    assign w_mnr = (Dw+1)'(w_vmin) + (Dw+1)'(r_q) + (w_hi_sel ? (Dw+1)'(1) : (Dw+1)'(0));
    assign w_rem_over = (r_rem >= $signed({1'b0, r_den}));
    assign w_rem_under = (r_rem < 0);
    assign w_block = !r_skip &&
                     (r_strict ? (r_num > r_lhs + r_p2) : (r_num >= r_lhs + r_p2));

    always_comb begin
        w_mnr_sel = w_mnr;
        w_rr = (Dw+1)'(i_cmd.row);
        w_cc = (Dw+1)'(i_cmd.col);
        w_rd_en = 1'b0;
        unique case (r_state)
            S_VP_RD: begin
                w_rr = (Dw+1)'(i_view_row);
                w_cc = (Dw+1)'(i_view_col);
                w_rd_en = 1'b1;
            end
            S_TG_RD: begin
                w_rd_en = 1'b1;
            end
            S_RD_LO, S_RD_HI: begin
                w_rr = r_pass ? w_mnr_sel : w_maj;
                w_cc = r_pass ? w_maj : w_mnr_sel;
                w_rd_en = 1'b1;
            end
            default: begin
            end
        endcase
        w_rd_oob = (w_rr < 0) || (32'(w_rr) >= MAX_ROWS) ||
                   (w_cc < 0) || (32'(w_cc) >= MAX_COLS);
        w_rd_addr = {RowAw'(w_rr), ColAw'(w_cc)};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid && !i_cmd.kind && i_cmd.in_grid) begin
            r_mem[{RowAw'(i_cmd.row), ColAw'(i_cmd.col)}] <= i_cmd.height;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
            r_rd_oob <= w_rd_oob;
        end
    end

    logic signed [HeightW-1:0] w_cell;
    assign w_cell = r_rd_oob ? i_no_data : r_rd;

    always_comb begin
        n_state = r_state;
        n_pass = r_pass;
        o_cmd_ready = 1'b0;
        w_fire_done = 1'b0;
        w_status = StVisible;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (!i_cmd.kind) begin
                        o_cmd_ready = 1'b1;
                    end else if (!r_ovalid || i_ready) begin
                        if (!i_cmd.in_grid || ({1'b0, i_view_row} >= i_rows) ||
                            ({1'b0, i_view_col} >= i_cols)) begin
                            o_cmd_ready = 1'b1;
                            w_fire_done = 1'b1;
                            w_status = StOutside;
                        end else begin
                            n_state = S_VP_RD;
                        end
                    end
                end
            end
            S_VP_RD: n_state = S_VP_WT;
            S_VP_WT: n_state = S_TG_RD;
            S_TG_RD: begin
                if (r_vp[HeightW-1:0] == i_no_data) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_TG_WT;
                end
            end
            S_TG_WT: begin
                n_state = S_PASS;
                n_pass = 1'b0;
            end
            S_PASS: n_state = S_STEP;
            S_STEP: begin
                if (r_k + Dw'(1) >= r_den) begin
                    if (r_pass) begin
                        n_state = S_DONE;
                    end else begin
                        n_pass = 1'b1;
                        n_state = S_PASS;
                    end
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (!w_rem_over && !w_rem_under) begin
                    n_state = S_RD_LO;
                end
            end
            S_RD_LO: n_state = r_exact ? S_WT_HI : S_RD_HI;
            S_RD_HI: n_state = S_WT_HI;
            S_WT_HI: n_state = S_MUL;
            S_MUL: n_state = S_CMP;
            S_CMP: begin
                if (w_block) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                o_cmd_ready = 1'b1;
                w_fire_done = 1'b1;
                w_status = r_ostatus;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass <= n_pass;
            if (w_fire_done) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire_done) begin
            r_ostatus <= w_status;
            r_orow <= i_cmd.row;
            r_ocol <= i_cmd.col;
        end
        unique case (r_state)
            S_IDLE: begin
                r_trow <= i_cmd.row;
                r_tcol <= i_cmd.col;
            end
            S_VP_WT: begin
                r_vp <= (HeightW+1)'(w_cell);
            end
            S_TG_RD: begin
                if (r_vp[HeightW-1:0] == i_no_data) r_ostatus <= StViewNoData;
            end
            S_TG_WT: begin
                r_dt <= (HeightW+1)'(w_cell) - r_vp;
                r_strict <= !((r_trow == i_view_row) || (r_tcol == i_view_col));
                if (w_cell == i_no_data) begin
                    r_ostatus <= StHidden;
                end else begin
                    r_ostatus <= StVisible;
                end
            end
            S_PASS: begin
                if (r_pass) begin
                    r_dmaj <= Dw'(r_tcol) - Dw'(i_view_col);
                    r_dmin <= Dw'(r_trow) - Dw'(i_view_row);
                end else begin
                    r_dmaj <= Dw'(r_trow) - Dw'(i_view_row);
                    r_dmin <= Dw'(r_tcol) - Dw'(i_view_col);
                end
                if (r_ostatus != StVisible) begin
                    r_den <= '0;
                end else if (r_pass) begin
                    r_den <= (r_tcol >= i_view_col) ? Dw'(r_tcol - i_view_col)
                                                    : Dw'(i_view_col - r_tcol);
                end else begin
                    r_den <= (r_trow >= i_view_row) ? Dw'(r_trow - i_view_row)
                                                    : Dw'(i_view_row - r_trow);
                end
                r_k <= '0;
                r_q <= '0;
                r_rem <= '0;
                r_exact <= 1'b1;
            end
            S_STEP: begin
                r_k <= r_k + Dw'(1);
                r_lhs <= Pw'(r_dt) * Pw'($signed({1'b0, r_k + Dw'(1)}));
                r_rem <= r_rem + (Dw+1)'(r_dmin);
            end
            S_NORM: begin
                if (w_rem_over) begin
                    r_rem <= r_rem - $signed({1'b0, r_den});
                    r_q <= r_q + Dw'(1);
                end else if (w_rem_under) begin
                    r_rem <= r_rem + $signed({1'b0, r_den});
                    r_q <= r_q - Dw'(1);
                end else begin
                    r_exact <= (r_rem == '0);
                end
            end
            S_RD_HI: begin
                r_lo <= w_cell;
                r_skip <= (w_cell == i_no_data);
            end
            S_WT_HI: begin
                if (r_exact) begin
                    r_skip <= (w_cell == i_no_data);
                    r_num <= Pw'((HeightW+1)'(w_cell) - r_vp) * Pw'($signed({1'b0, r_den}));
                    r_p2 <= '0;
                end else begin
                    r_skip <= r_skip || (w_cell == i_no_data);
                    r_num <= Pw'((HeightW+1)'(r_lo) - r_vp) * Pw'($signed({1'b0, r_den}));
                    r_p2 <= Pw'((HeightW+1)'(w_cell) - (HeightW+1)'(r_lo)) *
                            Pw'(r_rem);
                end
            end
            S_MUL: begin
                r_num <= r_num + r_p2;
                r_p2 <= '0;
            end
            S_CMP: begin
                if (w_block) r_ostatus <= StHidden;
            end
            default: begin
            end
        endcase
    end

endmodule
